[src/mp3rp_pkg.sv]
// Package with the constants and types shared by the reply frame parser.
`timescale 1ns / 1ps
`default_nettype none

package mp3rp_pkg;

  // Number of bytes held before the current one.
  localparam int unsigned WinDepth = 9;

  localparam int unsigned TrackW = 17;
  localparam int unsigned TotalW = 16;

  // Framing bytes.
  localparam logic [7:0] FRAME_END = 8'hEF;
  localparam logic [7:0] HDR_START = 8'h7E;
  localparam logic [7:0] HDR_VER   = 8'hFF;
  localparam logic [7:0] HDR_LEN   = 8'h06;

  // Reply codes.
  localparam logic [7:0] CODE_FINISHED = 8'h3D;
  localparam logic [7:0] CODE_CARD_ON  = 8'h3F;
  localparam logic [7:0] CODE_CARD_OFF = 8'h3B;
  localparam logic [7:0] CODE_TOTAL    = 8'h48;

  // Low parameter byte that marks the card as online.
  localparam logic [7:0] CARD_ON_PARAM = 8'h02;

  typedef logic [7:0] byte_t;

  // Entry 0 is the oldest byte, entry WinDepth-1 the newest.
  typedef byte_t [WinDepth-1:0] win_t;

  // Held status of the player.
  typedef struct packed {
    logic [TrackW-1:0] track;
    logic [TotalW-1:0] total;
    logic              card;
  } status_t;

  // Per-word decode outcome.
  typedef struct packed {
    logic  frame_ok;
    byte_t reply_code;
    logic  track_finished;
  } flags_t;

endpackage

`default_nettype wire

[src/mp3rp_decode.sv]
// Combinational frame check, status update and window shift for one byte.
`timescale 1ns / 1ps
`default_nettype none

module mp3rp_decode (
  input  var mp3rp_pkg::byte_t   rx_byte_i,
  input  var mp3rp_pkg::win_t    win_i,
  input  var mp3rp_pkg::status_t status_i,
  output mp3rp_pkg::win_t        win_o,
  output mp3rp_pkg::status_t     status_o,
  output mp3rp_pkg::flags_t      flags_o
);

  logic             is_end;
  logic             hdr_ok;
  mp3rp_pkg::byte_t code;
  mp3rp_pkg::byte_t hi;
  mp3rp_pkg::byte_t lo;

  assign is_end = (rx_byte_i == mp3rp_pkg::FRAME_END);
  assign hdr_ok = (win_i[0] == mp3rp_pkg::HDR_START) &&
                  (win_i[1] == mp3rp_pkg::HDR_VER) &&
                  (win_i[2] == mp3rp_pkg::HDR_LEN);
  assign code   = win_i[3];
  assign hi     = win_i[5];
  assign lo     = win_i[6];

  // The window is cleared after every end byte, otherwise it shifts by one.
  always_comb begin
    if (is_end) begin
      win_o = '0;
    end else begin
      win_o = {rx_byte_i, win_i[mp3rp_pkg::WinDepth-1:1]};
    end
  end

  always_comb begin
    status_o = status_i;
    flags_o  = '0;
    if (is_end && hdr_ok) begin
      flags_o.frame_ok   = 1'b1;
      flags_o.reply_code = code;
      unique case (code)
        mp3rp_pkg::CODE_FINISHED: begin
          status_o.track         = {1'b0, hi, lo} + 17'd1;
          flags_o.track_finished = 1'b1;
        end
        mp3rp_pkg::CODE_CARD_ON: begin
          status_o.card = (lo == mp3rp_pkg::CARD_ON_PARAM);
        end
        mp3rp_pkg::CODE_CARD_OFF: begin
          status_o.card = 1'b0;
        end
        mp3rp_pkg::CODE_TOTAL: begin
          status_o.total = {hi, lo};
        end
        default: begin
          status_o = status_i;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[src/mp3_module_reply_parser.sv]
// Top level of the reply frame parser for a serial audio player module.
// Usage:
//   The input channel carries one received UART byte per word (rx_byte_i),
//   offered with in_valid_i and held off by in_stall_o. The output channel
//   gives one result word per input word: the frame flags, the reply code and
//   the held status (current track, total tracks, card state), offered with
//   out_valid_o and held off by out_stall_i.
//   A byte of 0xEF closes a frame; the frame counts when the nine bytes held
//   before it start with 0x7E 0xFF 0x06. Status updates on track finished,
//   card online, card removed and track count replies.
// Pipeline and throughput:
//   An accepted byte lands in an input register. From there it is decoded
//   against the byte window and written to the output register, where its
//   result is offered. One word per cycle is sustained while out_stall_i is
//   low; the window shift and header compare fit between the registers.
// Reset:
//   Both stages empty, window zero, current track 1, total 0, card offline.
// Stall:
//   A stalled result holds its word. The input register still takes one more
//   byte; once both stages are full, in_stall_o rises until the result drains.
`timescale 1ns / 1ps
`default_nettype none

module mp3_module_reply_parser (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic        frame_ok_o,
  output logic [7:0]  reply_code_o,
  output logic        track_finished_o,
  output logic [16:0] current_track_o,
  output logic [15:0] total_tracks_o,
  output logic        card_ok_o
);

  // Input stage.
  logic             in_valid_q;
  mp3rp_pkg::byte_t in_byte_q;

  // Result stage.
  logic              out_valid_q;
  mp3rp_pkg::flags_t flags_q;

  // Parser state, updated when a word moves into the result stage.
  mp3rp_pkg::win_t    win_q;
  mp3rp_pkg::win_t    win_d;
  mp3rp_pkg::status_t status_q;
  mp3rp_pkg::status_t status_d;
  mp3rp_pkg::flags_t  flags_d;

  logic out_load;
  logic in_load;

  // The result register can take a new word when it is empty or draining.
  assign out_load   = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !out_load;
  assign in_load    = in_valid_i && !in_stall_o;

  mp3rp_decode u_decode (
    .rx_byte_i (in_byte_q),
    .win_i     (win_q),
    .status_i  (status_q),
    .win_o     (win_d),
    .status_o  (status_d),
    .flags_o   (flags_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= 1'b1;
    end else if (out_load) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q    <= 1'b0;
      win_q          <= '0;
      status_q.track <= 17'd1;
      status_q.total <= '0;
      status_q.card  <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
      win_q       <= win_d;
      status_q    <= status_d;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      flags_q <= flags_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_ok_o       = flags_q.frame_ok;
  assign reply_code_o     = flags_q.reply_code;
  assign track_finished_o = flags_q.track_finished;
  assign current_track_o  = status_q.track;
  assign total_tracks_o   = status_q.total;
  assign card_ok_o        = status_q.card;

  // A rejected frame or ordinary byte always reports code zero.
  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !frame_ok_o) |-> (reply_code_o == 8'h00))
    else $error("reply code set without an accepted frame");

  // A finished pulse belongs to an accepted track-finished frame.
  a_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && track_finished_o) |->
      (frame_ok_o && (reply_code_o == mp3rp_pkg::CODE_FINISHED)))
    else $error("finished pulse without a track finished reply");

  // The input is held off only while a full result stage is stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with room in the result stage");

  // The status only moves when a new result is loaded.
  a_status_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_load) |=> $stable(status_q))
    else $error("status changed without a word");

endmodule

`default_nettype wire
